// ===== rtl/core/vtc_pkg.sv =====
// Shared constants and codes for the volume threshold crop block.
package vtc_pkg;

    // Default sizing of the grid store.
    localparam int MAX_DIM_DEF     = 32;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed field widths.
    localparam int THR_W    = 23;
    localparam int SIZE_W   = 6;
    localparam int PMODE_W  = 2;
    localparam int STATUS_W = 3;
    localparam int BOUND_W  = 5;
    localparam int PHASE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_A     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_B     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_C     = 3'd5;

    // Register reset values.
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 23'd328;
    localparam logic [SIZE_W-1:0]  SIZE_RST      = 6'd32;

    // Input operations.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_TAKEN    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BOX      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DATA     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTREADY = 3'd4;

    // Phase codes.
    localparam logic [PHASE_W-1:0] PH_NONE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_POS  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_NEG  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_AUTO = 2'd3;

endpackage

// ===== rtl/core/vtc_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module vtc_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/volume_threshold_crop.sv =====
// Top level of the volume threshold crop block: grid store, sequencer and shared arithmetic.
// Pushed words are stored in a-b-c row-major order and summed; a push passes through two size
// multiplications, then the store write, and then the state that hands the result
// word to the output register. The push that completes the grid then runs one
// restoring division for the mean, one quotient bit per cycle, and, with a nonzero
// threshold, a scan of the whole grid, each point read from the store and then
// given its phase write-back and box update; the block takes no word meanwhile.
// A pull of the box bounds goes straight to output; a pull of a cropped data value passes
// through two address multiplications, the registered store read, saturation and output.
module volume_threshold_crop #(
    parameter int MAX_DIM     = vtc_pkg::MAX_DIM_DEF,
    parameter int SAMPLE_BITS = vtc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [vtc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vtc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: sample, zero padded to whole bytes.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    // tuser: operation.
    input  logic                                s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: value, a_first, a_final, b_first, b_final, c_first, c_final, phase_used, padding.
    output logic [((SAMPLE_BITS+32+7)/8)*8-1:0] m_tdata,
    // tuser: status.
    output logic [vtc_pkg::STATUS_W-1:0]        m_tuser,
    output logic                                m_tlast
);

    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = IDX_W + 1;
    localparam int ADDR_W  = 3 * IDX_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int CNT_W   = ADDR_W + 1;
    localparam int SUM_W   = SAMPLE_BITS + ADDR_W + 1;
    localparam int DCNT_W  = $clog2(SUM_W + 1);
    localparam int MEAN_W  = SAMPLE_BITS + 1;
    localparam int DIFF_W  = SAMPLE_BITS + 2;
    localparam int CMP_W   = 34;
    localparam int T1_W    = 2 * IDX_W;
    localparam int OUT_W   = ((SAMPLE_BITS + 32 + 7) / 8) * 8;
    localparam int PAD_W   = OUT_W - SAMPLE_BITS - 32;

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {M_LOADING, M_BOX, M_STREAM, M_DONE} mode_t;
    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_WRITE, S_EMIT, S_DIV_INIT, S_DIV, S_DIV_END,
        S_SCAN_RD, S_SCAN_PROC, S_RD_A, S_RD_B, S_RD_C, S_RD_D
    } seq_t;

    // Configuration registers.
    logic [vtc_pkg::THR_W-1:0]   threshold_reg;
    logic                        normalize_reg;
    logic [vtc_pkg::PMODE_W-1:0] phase_mode_reg;
    logic [vtc_pkg::SIZE_W-1:0]  size_a_reg, size_b_reg, size_c_reg;

    // Block state.
    seq_t                          state_reg;
    mode_t                         mode_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [CNT_W-1:0]              count_reg;
    logic signed [MEAN_W-1:0]      mean_reg;
    logic [DIM_W-1:0]              dim_a_reg, dim_b_reg, dim_c_reg;
    logic [2*DIM_W-1:0]            prod_ab_reg;
    logic [CNT_W-1:0]              total_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [IDX_W-1:0]              lo_reg [3];
    logic [IDX_W-1:0]              hi_reg [3];
    logic [IDX_W-1:0]              pos_reg [3];
    logic                          found_reg;
    logic [vtc_pkg::PHASE_W-1:0]   phase_reg;
    logic [vtc_pkg::PHASE_W-1:0]   scan_phase_reg;

    // Divider.
    logic [SUM_W-1:0]  num_reg;
    logic [SUM_W-1:0]  quot_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    // Scan and readout addressing.
    logic [ADDR_W-1:0] scan_addr_reg;
    logic [IDX_W-1:0]  scan_pt_reg [3];
    logic [T1_W-1:0]   t1_reg;
    logic [ADDR_W-1:0] rd_addr_reg;

    // Pending result word.
    logic [vtc_pkg::STATUS_W-1:0]  pend_status_reg;
    logic signed [SAMPLE_BITS-1:0] pend_value_reg;
    logic                          pend_box_reg;
    logic                          pend_phase_reg;
    logic                          pend_last_reg;
    logic                          pend_finish_reg;

    // Store ports.
    logic                          ram_wr_en;
    logic [ADDR_W-1:0]             ram_wr_addr;
    logic [SAMPLE_BITS-1:0]        ram_wr_data;
    logic [ADDR_W-1:0]             ram_rd_addr;
    logic [SAMPLE_BITS-1:0]        ram_rd_data;

    // Combinational helpers.
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          slot_free;
    logic [CNT_W-1:0]              count_inc;
    logic [CNT_W:0]                div_trial;
    logic signed [SAMPLE_BITS-1:0] stored;
    logic signed [SAMPLE_BITS-1:0] phased;
    logic signed [CMP_W-1:0]       phased_x;
    logic signed [CMP_W-1:0]       thr_x;
    logic                          hit;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [SAMPLE_BITS-1:0] diff_sat;
    logic [IDX_W+DIM_W:0]          t1_full;
    logic [T1_W+DIM_W:0]           addr_full;
    logic [3*DIM_W-1:0]            total_full;
    logic [SUM_W-1:0]              sum_abs;
    logic                          scan_end_c, scan_end_b, scan_end_a;
    logic                          rd_end_c, rd_end_b, rd_end_a;

    // Size register clamped to 1..MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [vtc_pkg::SIZE_W-1:0] s);
        logic [DIM_W-1:0] r;
        if (s == '0) begin
            r = DIM_W'(1);
        end else if (int'(s) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(s);
        end
        return r;
    endfunction

    // Index shown in a 5-bit bound field.
    function automatic logic [vtc_pkg::BOUND_W-1:0] bnd(input logic [IDX_W-1:0] x);
        logic [IDX_W+vtc_pkg::BOUND_W-1:0] w;
        w = {{vtc_pkg::BOUND_W{1'b0}}, x};
        return w[vtc_pkg::BOUND_W-1:0];
    endfunction

    assign in_sample = s_tdata[SAMPLE_BITS-1:0];
    assign slot_free = !m_tvalid || m_tready;
    assign count_inc = count_reg + CNT_W'(1);
    assign s_tready  = (state_reg == S_IDLE);
    assign total_full = prod_ab_reg * dim_c_reg;
    assign sum_abs    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // One restoring division step.
    assign div_trial = {rem_reg, num_reg[SUM_W-1]};

    // Phase selection and threshold test on the word read back during the scan.
    assign stored = ram_rd_data;
    always_comb begin
        phased = stored;
        case (scan_phase_reg)
            vtc_pkg::PH_POS: begin
                if (stored < 0) phased = '0;
            end
            vtc_pkg::PH_NEG: begin
                if (stored > 0) begin
                    phased = '0;
                end else if (stored == SMIN) begin
                    phased = SMAX;
                end else begin
                    phased = -stored;
                end
            end
            default: phased = stored;
        endcase
    end
    assign phased_x = {{(CMP_W-SAMPLE_BITS){phased[SAMPLE_BITS-1]}}, phased};
    assign thr_x    = {{(CMP_W-vtc_pkg::THR_W){1'b0}}, threshold_reg};
    assign hit      = (phased_x > thr_x) || (phased_x < -thr_x);

    // Readout value: stored word minus mean, saturated.
    assign diff = {{2{stored[SAMPLE_BITS-1]}}, stored}
                - {mean_reg[MEAN_W-1], mean_reg};
    always_comb begin
        if (diff > $signed({{2{1'b0}}, SMAX})) begin
            diff_sat = SMAX;
        end else if (diff < $signed({{2{1'b1}}, SMIN})) begin
            diff_sat = SMIN;
        end else begin
            diff_sat = diff[SAMPLE_BITS-1:0];
        end
    end

    // Readout address arithmetic, one multiplication per cycle.
    assign t1_full   = pos_reg[0] * dim_b_reg + (IDX_W+DIM_W+1)'(pos_reg[1]);
    assign addr_full = t1_reg * dim_c_reg + (T1_W+DIM_W+1)'(pos_reg[2]);

    // End-of-row tests for the scan and the readout walk.
    assign scan_end_c = ({1'b0, scan_pt_reg[2]} == dim_c_reg - DIM_W'(1));
    assign scan_end_b = ({1'b0, scan_pt_reg[1]} == dim_b_reg - DIM_W'(1));
    assign scan_end_a = ({1'b0, scan_pt_reg[0]} == dim_a_reg - DIM_W'(1));
    assign rd_end_c   = (pos_reg[2] >= hi_reg[2]);
    assign rd_end_b   = (pos_reg[1] >= hi_reg[1]);
    assign rd_end_a   = (pos_reg[0] >= hi_reg[0]);

    // Store port selection.
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = scan_addr_reg;
        ram_wr_data = phased;
        ram_rd_addr = scan_addr_reg;
        if (state_reg == S_WRITE) begin
            ram_wr_en   = (mode_reg == M_LOADING);
            ram_wr_addr = count_reg[ADDR_W-1:0];
            ram_wr_data = sample_reg;
        end else if (state_reg == S_SCAN_PROC) begin
            ram_wr_en   = 1'b1;
        end
        if (state_reg == S_RD_C) begin
            ram_rd_addr = rd_addr_reg;
        end
    end

    vtc_ram #(
        .WIDTH  (SAMPLE_BITS),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= vtc_pkg::THRESHOLD_RST;
            normalize_reg  <= 1'b0;
            phase_mode_reg <= vtc_pkg::PH_NONE;
            size_a_reg     <= vtc_pkg::SIZE_RST;
            size_b_reg     <= vtc_pkg::SIZE_RST;
            size_c_reg     <= vtc_pkg::SIZE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                vtc_pkg::REG_THRESHOLD:  threshold_reg  <= cfg_data[vtc_pkg::THR_W-1:0];
                vtc_pkg::REG_NORMALIZE:  normalize_reg  <= cfg_data[0];
                vtc_pkg::REG_PHASE_MODE: phase_mode_reg <= cfg_data[vtc_pkg::PMODE_W-1:0];
                vtc_pkg::REG_SIZE_A:     size_a_reg     <= cfg_data[vtc_pkg::SIZE_W-1:0];
                vtc_pkg::REG_SIZE_B:     size_b_reg     <= cfg_data[vtc_pkg::SIZE_W-1:0];
                vtc_pkg::REG_SIZE_C:     size_c_reg     <= cfg_data[vtc_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, block state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            mode_reg        <= M_LOADING;
            sum_reg         <= '0;
            count_reg       <= '0;
            mean_reg        <= '0;
            found_reg       <= 1'b0;
            phase_reg       <= vtc_pkg::PH_NONE;
            pend_finish_reg <= 1'b0;
            m_tvalid        <= 1'b0;
            dim_a_reg       <= DIM_W'(1);
            dim_b_reg       <= DIM_W'(1);
            dim_c_reg       <= DIM_W'(1);
            for (int k = 0; k < 3; k++) begin
                lo_reg[k]  <= '0;
                hi_reg[k]  <= '0;
                pos_reg[k] <= '0;
            end
        end else begin
            // The emit state loads a new word itself whenever the slot frees.
            if (m_tvalid && m_tready && state_reg != S_EMIT) begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                // Take a word and decide what it does.
                S_IDLE: begin
                    if (s_tvalid) begin
                        pend_status_reg <= vtc_pkg::ST_NOTREADY;
                        pend_value_reg  <= '0;
                        pend_box_reg    <= 1'b0;
                        pend_phase_reg  <= 1'b0;
                        pend_last_reg   <= 1'b0;
                        pend_finish_reg <= 1'b0;
                        state_reg       <= S_EMIT;
                        if (s_tuser == vtc_pkg::OP_PUSH) begin
                            if (mode_reg == M_LOADING || mode_reg == M_DONE) begin
                                if (mode_reg == M_DONE) begin
                                    sum_reg   <= '0;
                                    count_reg <= '0;
                                end
                                mode_reg   <= M_LOADING;
                                sample_reg <= in_sample;
                                dim_a_reg  <= clamp_dim(size_a_reg);
                                dim_b_reg  <= clamp_dim(size_b_reg);
                                dim_c_reg  <= clamp_dim(size_c_reg);
                                state_reg  <= S_MUL1;
                            end
                        end else if (mode_reg == M_BOX) begin
                            pend_phase_reg <= 1'b1;
                            if (!found_reg) begin
                                pend_status_reg <= vtc_pkg::ST_EMPTY;
                                mode_reg        <= M_DONE;
                            end else begin
                                pend_status_reg <= vtc_pkg::ST_BOX;
                                pend_box_reg    <= 1'b1;
                                mode_reg        <= M_STREAM;
                            end
                        end else if (mode_reg == M_STREAM) begin
                            state_reg <= S_RD_A;
                        end
                    end
                end
                S_MUL1: begin
                    prod_ab_reg <= dim_a_reg * dim_b_reg;
                    state_reg   <= S_MUL2;
                end
                S_MUL2: begin
                    total_reg <= total_full[CNT_W-1:0];
                    state_reg <= S_WRITE;
                end
                // Store write happens here through the port selection.
                S_WRITE: begin
                    sum_reg         <= sum_reg + SUM_W'(sample_reg);
                    count_reg       <= count_inc;
                    pend_status_reg <= vtc_pkg::ST_TAKEN;
                    pend_finish_reg <= (count_inc >= total_reg);
                    state_reg       <= S_EMIT;
                end
                // Hand the pending word to the output register.
                S_EMIT: begin
                    if (slot_free) begin
                        m_tvalid <= 1'b1;
                        m_tuser  <= pend_status_reg;
                        m_tlast  <= pend_last_reg;
                        m_tdata  <= {
                            {PAD_W{1'b0}},
                            pend_phase_reg ? phase_reg : vtc_pkg::PH_NONE,
                            pend_box_reg ? bnd(hi_reg[2]) : {vtc_pkg::BOUND_W{1'b0}},
                            pend_box_reg ? bnd(lo_reg[2]) : {vtc_pkg::BOUND_W{1'b0}},
                            pend_box_reg ? bnd(hi_reg[1]) : {vtc_pkg::BOUND_W{1'b0}},
                            pend_box_reg ? bnd(lo_reg[1]) : {vtc_pkg::BOUND_W{1'b0}},
                            pend_box_reg ? bnd(hi_reg[0]) : {vtc_pkg::BOUND_W{1'b0}},
                            pend_box_reg ? bnd(lo_reg[0]) : {vtc_pkg::BOUND_W{1'b0}},
                            pend_value_reg
                        };
                        state_reg <= pend_finish_reg ? S_DIV_INIT : S_IDLE;
                    end
                end
                // Mean: (|sum| + total/2) / total by restoring division.
                S_DIV_INIT: begin
                    num_reg   <= sum_abs + SUM_W'(total_reg >> 1);
                    quot_reg  <= '0;
                    rem_reg   <= '0;
                    dcnt_reg  <= DCNT_W'(SUM_W);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    num_reg <= num_reg << 1;
                    if (div_trial >= {1'b0, total_reg}) begin
                        rem_reg  <= CNT_W'(div_trial - {1'b0, total_reg});
                        quot_reg <= {quot_reg[SUM_W-2:0], 1'b1};
                    end else begin
                        rem_reg  <= div_trial[CNT_W-1:0];
                        quot_reg <= {quot_reg[SUM_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(1)) begin
                        state_reg <= S_DIV_END;
                    end
                end
                // Mean, phase choice, and the box setup.
                S_DIV_END: begin
                    if (!normalize_reg) begin
                        mean_reg <= '0;
                    end else if (sum_reg[SUM_W-1]) begin
                        mean_reg <= -$signed(quot_reg[MEAN_W-1:0]);
                    end else begin
                        mean_reg <= $signed(quot_reg[MEAN_W-1:0]);
                    end
                    if (threshold_reg == '0) begin
                        phase_reg <= vtc_pkg::PH_NONE;
                        found_reg <= 1'b1;
                        lo_reg[0] <= '0;
                        lo_reg[1] <= '0;
                        lo_reg[2] <= '0;
                        hi_reg[0] <= IDX_W'(dim_a_reg - DIM_W'(1));
                        hi_reg[1] <= IDX_W'(dim_b_reg - DIM_W'(1));
                        hi_reg[2] <= IDX_W'(dim_c_reg - DIM_W'(1));
                        pos_reg[0] <= '0;
                        pos_reg[1] <= '0;
                        pos_reg[2] <= '0;
                        mode_reg   <= M_BOX;
                        state_reg  <= S_IDLE;
                    end else begin
                        if (phase_mode_reg == vtc_pkg::PH_AUTO) begin
                            scan_phase_reg <= (!sum_reg[SUM_W-1] && sum_reg != '0)
                                            ? vtc_pkg::PH_POS : vtc_pkg::PH_NEG;
                            phase_reg      <= (!sum_reg[SUM_W-1] && sum_reg != '0)
                                            ? vtc_pkg::PH_POS : vtc_pkg::PH_NEG;
                        end else begin
                            scan_phase_reg <= phase_mode_reg;
                            phase_reg      <= phase_mode_reg;
                        end
                        found_reg      <= 1'b0;
                        scan_addr_reg  <= '0;
                        scan_pt_reg[0] <= '0;
                        scan_pt_reg[1] <= '0;
                        scan_pt_reg[2] <= '0;
                        state_reg      <= S_SCAN_RD;
                    end
                end
                // Read one grid point.
                S_SCAN_RD: begin
                    state_reg <= S_SCAN_PROC;
                end
                // Write back the phased word, widen the box, step the point.
                S_SCAN_PROC: begin
                    if (hit) begin
                        found_reg <= 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            if (!found_reg || scan_pt_reg[k] < lo_reg[k]) begin
                                lo_reg[k] <= scan_pt_reg[k];
                            end
                            if (!found_reg || scan_pt_reg[k] > hi_reg[k]) begin
                                hi_reg[k] <= scan_pt_reg[k];
                            end
                        end
                    end
                    scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
                    state_reg     <= S_SCAN_RD;
                    if (!scan_end_c) begin
                        scan_pt_reg[2] <= scan_pt_reg[2] + IDX_W'(1);
                    end else begin
                        scan_pt_reg[2] <= '0;
                        if (!scan_end_b) begin
                            scan_pt_reg[1] <= scan_pt_reg[1] + IDX_W'(1);
                        end else begin
                            scan_pt_reg[1] <= '0;
                            if (!scan_end_a) begin
                                scan_pt_reg[0] <= scan_pt_reg[0] + IDX_W'(1);
                            end else begin
                                state_reg <= S_RD_A;
                                mode_reg  <= M_BOX;
                            end
                        end
                    end
                end
                // Readout: first address product, or the end of the scan.
                S_RD_A: begin
                    if (mode_reg == M_BOX) begin
                        // The scan just finished: an empty box shows zero bounds.
                        for (int k = 0; k < 3; k++) begin
                            if (!found_reg) begin
                                lo_reg[k]  <= '0;
                                hi_reg[k]  <= '0;
                                pos_reg[k] <= '0;
                            end else begin
                                pos_reg[k] <= lo_reg[k];
                            end
                        end
                        state_reg <= S_IDLE;
                    end else begin
                        t1_reg    <= t1_full[T1_W-1:0];
                        state_reg <= S_RD_B;
                    end
                end
                S_RD_B: begin
                    rd_addr_reg <= addr_full[ADDR_W-1:0];
                    state_reg   <= S_RD_C;
                end
                S_RD_C: begin
                    state_reg <= S_RD_D;
                end
                // Data word ready: subtract mean, step the readout point.
                S_RD_D: begin
                    pend_status_reg <= vtc_pkg::ST_DATA;
                    pend_value_reg  <= diff_sat;
                    pend_box_reg    <= 1'b1;
                    pend_phase_reg  <= 1'b1;
                    pend_last_reg   <= 1'b0;
                    state_reg       <= S_EMIT;
                    if (!rd_end_c) begin
                        pos_reg[2] <= pos_reg[2] + IDX_W'(1);
                    end else begin
                        pos_reg[2] <= lo_reg[2];
                        if (!rd_end_b) begin
                            pos_reg[1] <= pos_reg[1] + IDX_W'(1);
                        end else begin
                            pos_reg[1] <= lo_reg[1];
                            if (!rd_end_a) begin
                                pos_reg[0] <= pos_reg[0] + IDX_W'(1);
                            end else begin
                                pend_last_reg <= 1'b1;
                                mode_reg      <= M_DONE;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
